@@ hdl/ncd_pkg.sv @@
// Package for the nearest-car dispatcher: word kinds and fixed field widths.
// No dependencies; imported by the dispatcher top level.
`default_nettype none

package ncd_pkg;

    // Width of the cars-in-use register and of the car number fields.
    localparam int CFG_W     = 4;
    localparam int CAR_NUM_W = 3;
    localparam int OUT_W     = 8;

    // Input word kinds carried on tuser.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

endpackage

`default_nettype wire

@@ hdl/nearest_car_dispatcher.sv @@
// Nearest-car dispatcher top level: car status table, rotating scan sequencer
// and output register. Depends on ncd_pkg and ncd_ram.
`default_nettype none

//  Channel   Direction  Handshake                    Contents
//  s_axis    in         tvalid/tready                tuser kind, tdata status or request
//  m_axis    out        tvalid/tready                tuser none_available, tdata chosen_car
//  cfg       in         i_cfg_we, no wait            cars_in_use
//
//  A status word is written into the car table at the edge that accepts it;
//  the next word can follow in the following cycle.
//  A request word first places the scan start, wrapping it below the car count by
//  repeated subtraction, then reads each car in use through the single table read port
//  and the shared distance/compare unit, then loads the output register. With no cars
//  in use it skips straight to the output register.
//  Reset (synchronous, active low) clears the per-car valid bits at once, so every car
//  reads as floor 1 and not faulted until it is first reported; no clearing pass runs.
//  A result waiting on m_axis does not stop status words; a later request holds in its
//  final step until the output register is free.

module nearest_car_dispatcher
    import ncd_pkg::*;
#(
    parameter int MAX_CARS   = 8,
    parameter int FLOOR_BITS = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    input  wire logic i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,   // cars_in_use

    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // tdata, lowest bit up: request_floor, car_number, car_floor, car_faulted, zero fill
    input  wire logic [((2*FLOOR_BITS+CAR_NUM_W+1+7)/8)*8-1:0] s_axis_tdata,
    // tuser: kind
    input  wire logic s_axis_tuser,

    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // tdata, lowest bit up: chosen_car, zero fill
    output logic [OUT_W-1:0] m_axis_tdata,
    // tuser: none_available
    output logic      m_axis_tuser
);

    localparam int CAR_W = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CNT_W = (CAR_W > CFG_W) ? CAR_W : CFG_W;
    localparam int ENT_W = FLOOR_BITS + 1;

    // Field positions in the input tdata.
    localparam int RQ_LO = 0;
    localparam int CN_LO = FLOOR_BITS;
    localparam int CF_LO = FLOOR_BITS + CAR_NUM_W;
    localparam int FT_LO = 2*FLOOR_BITS + CAR_NUM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]      r_cfg;
    logic [CFG_W-1:0]      r_n;
    logic [FLOOR_BITS-1:0] r_req_floor;
    logic [CNT_W-1:0]      r_pos;
    logic [CFG_W-1:0]      r_left;
    logic                  r_pend;
    logic [CNT_W-1:0]      r_pend_car;
    logic                  r_rd_vld;
    logic                  r_found;
    logic [CNT_W-1:0]      r_best;
    logic [FLOOR_BITS-1:0] r_best_dist;
    logic [CNT_W-1:0]      r_last;
    logic                  r_any;
    logic [MAX_CARS-1:0]   r_vld;
    logic                  r_m_valid;
    logic [CAR_NUM_W-1:0]  r_m_car;
    logic                  r_m_none;

    // Input fields.
    logic [FLOOR_BITS-1:0] in_req_floor;
    logic [CAR_NUM_W-1:0]  in_car;
    logic [FLOOR_BITS-1:0] in_car_floor;
    logic                  in_faulted;

    assign in_req_floor = s_axis_tdata[RQ_LO +: FLOOR_BITS];
    assign in_car       = s_axis_tdata[CN_LO +: CAR_NUM_W];
    assign in_car_floor = s_axis_tdata[CF_LO +: FLOOR_BITS];
    assign in_faulted   = s_axis_tdata[FT_LO];

    // Effective number of cars: the register saturated at the table depth.
    logic [CFG_W-1:0] n_cars;
    always_comb begin
        if (32'(r_cfg) > MAX_CARS) begin
            n_cars = CFG_W'(MAX_CARS);
        end else begin
            n_cars = r_cfg;
        end
    end

    logic accept;
    logic status_wr;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign status_wr     = accept && (s_axis_tuser == KIND_STATUS)
                           && (CFG_W'(in_car) < n_cars);

    // The output register takes a new result when it is empty or being drained.
    logic out_load;
    assign out_load = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    logic [CAR_W-1:0] wr_addr;
    logic [CAR_W-1:0] rd_addr;
    logic             rd_en;
    logic [ENT_W-1:0] rd_data;

    assign wr_addr = CAR_W'(in_car);
    assign rd_addr = r_pos[CAR_W-1:0];
    assign rd_en   = (r_state == ST_SCAN) && (r_left != '0);

    // Each entry holds {faulted, floor}.
    ncd_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_CARS)
    ) u_car_table (
        .i_clk  (i_clk),
        .i_we   (status_wr),
        .i_waddr(wr_addr),
        .i_wdata({in_faulted, in_car_floor}),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // Shared distance and compare unit. A car that was never reported reads
    // as floor 1 and in service.
    logic [FLOOR_BITS-1:0] n_car_floor;
    logic                  n_car_fault;
    logic [FLOOR_BITS-1:0] n_dist;
    logic                  n_better;

    always_comb begin
        n_car_floor = r_rd_vld ? rd_data[FLOOR_BITS-1:0] : FLOOR_BITS'(1);
        n_car_fault = r_rd_vld ? rd_data[FLOOR_BITS] : 1'b0;
        if (n_car_floor >= r_req_floor) begin
            n_dist = n_car_floor - r_req_floor;
        end else begin
            n_dist = r_req_floor - n_car_floor;
        end
        n_better = r_pend && !n_car_fault && (!r_found || (n_dist < r_best_dist));
    end

    logic [CNT_W-1:0] n_pos_inc;
    assign n_pos_inc = r_pos + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= CFG_W'(1);
            r_last    <= '0;
            r_any     <= 1'b0;
            r_vld     <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
            r_found   <= 1'b0;
            r_left    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (status_wr) begin
                r_vld[wr_addr] <= 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept && (s_axis_tuser == KIND_REQUEST)) begin
                        r_req_floor <= in_req_floor;
                        r_n         <= n_cars;
                        r_found     <= 1'b0;
                        r_pend      <= 1'b0;
                        r_pos       <= r_any ? (r_last + CNT_W'(1)) : '0;
                        if (n_cars == '0) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_NORM;
                        end
                    end
                end

                ST_NORM: begin
                    // Bring the start point below the car count by repeated subtraction.
                    if (r_pos >= CNT_W'(r_n)) begin
                        r_pos <= r_pos - CNT_W'(r_n);
                    end else begin
                        r_left  <= r_n;
                        r_state <= ST_SCAN;
                    end
                end

                ST_SCAN: begin
                    if (n_better) begin
                        r_found     <= 1'b1;
                        r_best      <= r_pend_car;
                        r_best_dist <= n_dist;
                    end
                    if (r_left != '0) begin
                        r_rd_vld   <= r_vld[rd_addr];
                        r_pend_car <= r_pos;
                        r_pend     <= 1'b1;
                        r_left     <= r_left - CFG_W'(1);
                        r_pos      <= (n_pos_inc == CNT_W'(r_n)) ? '0 : n_pos_inc;
                    end else begin
                        r_pend <= 1'b0;
                        if (r_pend) begin
                            r_state <= ST_DONE;
                        end
                    end
                end

                ST_DONE: begin
                    if (out_load) begin
                        r_m_none  <= !r_found;
                        r_m_car   <= r_found ? r_best[CAR_NUM_W-1:0] : '0;
                        if (r_found) begin
                            r_last <= r_best;
                            r_any  <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_W-CAR_NUM_W){1'b0}}, r_m_car};
    assign m_axis_tuser  = r_m_none;

    // The scan never addresses a car outside the count taken at the request.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_pos < CNT_W'(r_n)))
        else $error("scan position beyond car count");

    // A status word never moves the rotation point.
    a_status_keeps_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_axis_tuser == KIND_STATUS)) |=> $stable(r_last) && $stable(r_any))
        else $error("status word changed rotation point");

    // A result flagged as having no car carries car zero.
    a_none_car_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("no-car result with nonzero car");

    // Every issued read counts down the cars left to scan.
    a_left_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_left != '0) |=> (r_left == $past(r_left) - CFG_W'(1)))
        else $error("scan counter skipped");

    // A chosen car is always below the car count of its request.
    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_found) |-> (r_best < CNT_W'(r_n)))
        else $error("chosen car out of range");

endmodule

`default_nettype wire

@@ hdl/ncd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ncd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
